@@ hdl/ptd_pkg.sv @@
// ----------------------------------------------------------------------------
// ptd_pkg: shared types and constants for the TLP stream deframer
// Holds the item record that passes from the front part to the back part,
// the kind and phase codes, and the fixed limits of the packet format.
// ----------------------------------------------------------------------------
package ptd_pkg;

   // Fixed field widths of the stream.
   localparam int DWORD_W = 32;
   localparam int LEN_W   = 11;
   localparam int KIND_W  = 3;

   // Packet format limits.
   localparam logic [LEN_W-1:0] FULL_LENGTH        = 11'h400;
   localparam logic [LEN_W-1:0] MAX_PAYLOAD_DWORDS = 11'd1024;
   localparam logic [2:0]       FMT_PREFIX         = 3'd4;
   localparam logic [2:0]       FMT_FIRST_BAD      = 3'd5;
   localparam logic [2:0]       FMT_FIRST_DATA     = 3'd2;

   // Default depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 4;

   // Label carried by every result item.
   typedef enum logic [KIND_W-1:0] {
      KIND_PREFIX    = 3'd0,
      KIND_HEADER    = 3'd1,
      KIND_PAYLOAD   = 3'd2,
      KIND_DIGEST    = 3'd3,
      KIND_MALFORMED = 3'd4
   } kind_type;

   // Section of the packet that the next dword belongs to.
   typedef enum logic [1:0] {
      PHASE_LEAD    = 2'd0,
      PHASE_HEADER  = 2'd1,
      PHASE_PAYLOAD = 2'd2,
      PHASE_DIGEST  = 2'd3
   } phase_type;

   // One classified item on its way to the back part.
   typedef struct packed {
      kind_type             kind;
      logic [DWORD_W-1:0]   dword;
      logic [LEN_W-1:0]     len;
      logic                 eop;
   } item_type;

   // Status of the queue, seen by both neighbours.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Reverse the byte order of a dword.
   function automatic logic [DWORD_W-1:0] swap32(input logic [DWORD_W-1:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

@@ hdl/pcie_tlp_stream_deframer.sv @@
// ----------------------------------------------------------------------------
// pcie_tlp_stream_deframer: TLP dword stream deframer
// Splits a stream of raw TLP dwords into packets and labels every dword.
//
//   channel   handshake          payload
//   req       push / full        raw_dword (32)
//   rsp       pop / empty        kind (3), out_dword (32), payload_dwords (11),
//                                end_of_packet (1)
//
// One dword is accepted per cycle while the queue is not full; each gives exactly one result.
// The edge that accepts a dword writes its result into the queue; the result
// moves on to the output register once that register is free or being
// popped, and is then offered on rsp.
// Reset is synchronous and empties the queue and the output register; the
// tracker waits for a packet leader.
// When rsp is not popped the queue fills and full rises after QUEUE_DEPTH
// items plus the one held at the output.
// ----------------------------------------------------------------------------
module pcie_tlp_stream_deframer #(
   parameter int QUEUE_DEPTH = ptd_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [ptd_pkg::DWORD_W-1:0]   req_raw_dword,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [ptd_pkg::KIND_W-1:0]    rsp_kind,
   output logic [ptd_pkg::DWORD_W-1:0]   rsp_out_dword,
   output logic [ptd_pkg::LEN_W-1:0]     rsp_payload_dwords,
   output logic                          rsp_end_of_packet
);

   logic                    accept;
   logic                    q_pop;
   ptd_pkg::item_type       front_item;
   ptd_pkg::item_type       head_item;
   ptd_pkg::item_type       out_item;
   ptd_pkg::q_status_type   q_status;

   assign accept   = req_push && !q_status.full;
   assign req_full = q_status.full;

   // Front part: packet tracking and labelling.
   ptd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .raw_dword (req_raw_dword),
      .item      (front_item)
   );

   // Decoupling queue.
   ptd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .pop       (q_pop),
      .head_item (head_item),
      .status    (q_status)
   );

   // Back part: byte order and result register.
   ptd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_item (head_item),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .out_pop   (rsp_pop),
      .out_empty (rsp_empty),
      .out_item  (out_item)
   );

   assign rsp_kind           = out_item.kind;
   assign rsp_out_dword      = out_item.dword;
   assign rsp_payload_dwords = out_item.len;
   assign rsp_end_of_packet  = out_item.eop;

   // The queue can never report full and empty at once.
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty together");

   // After reset no result is on offer.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result offered straight after reset");

   // A malformed leader or a digest always closes its packet.
   a_closing_kinds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (out_item.kind == ptd_pkg::KIND_MALFORMED ||
                      out_item.kind == ptd_pkg::KIND_DIGEST)) |-> rsp_end_of_packet)
      else $error("malformed or digest item without end of packet");

   // A prefix carries no length and does not end a packet.
   a_prefix_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && out_item.kind == ptd_pkg::KIND_PREFIX) |->
         (rsp_payload_dwords == '0 && !rsp_end_of_packet))
      else $error("prefix item with length or end of packet");

endmodule

@@ hdl/ptd_front.sv @@
// ----------------------------------------------------------------------------
// ptd_front: packet tracker and classifier
// Accepts raw dwords, follows the packet structure with small counters and
// labels each dword with its kind, the packet payload length and end of packet.
// ----------------------------------------------------------------------------
module ptd_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [ptd_pkg::DWORD_W-1:0]  raw_dword,
   output ptd_pkg::item_type            item
);

   ptd_pkg::phase_type          phase_ff, phase_in;
   logic [1:0]                  header_left_ff, header_left_in;
   logic [ptd_pkg::LEN_W-1:0]   payload_left_ff, payload_left_in;
   logic                        digest_pending_ff, digest_pending_in;
   logic [ptd_pkg::LEN_W-1:0]   packet_len_ff, packet_len_in;

   logic [2:0]                  fmt;
   logic                        td;
   logic [9:0]                  len_field;
   logic [ptd_pkg::LEN_W-1:0]   len_decoded;
   logic                        bad_leader;

   // Leader fields, decoded in wire order.
   assign fmt         = raw_dword[7:5];
   assign td          = raw_dword[23];
   assign len_field   = {raw_dword[17:16], raw_dword[31:24]};
   assign len_decoded = (len_field == 10'd0) ? ptd_pkg::FULL_LENGTH
                                             : {1'b0, len_field};
   assign bad_leader  = (fmt >= ptd_pkg::FMT_FIRST_BAD) ||
                        ((fmt >= ptd_pkg::FMT_FIRST_DATA) &&
                         (len_decoded > ptd_pkg::MAX_PAYLOAD_DWORDS));

   // State registers, advanced only when an item is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= ptd_pkg::PHASE_LEAD;
         header_left_ff    <= '0;
         payload_left_ff   <= '0;
         digest_pending_ff <= 1'b0;
         packet_len_ff     <= '0;
      end else if (accept) begin
         phase_ff          <= phase_in;
         header_left_ff    <= header_left_in;
         payload_left_ff   <= payload_left_in;
         digest_pending_ff <= digest_pending_in;
         packet_len_ff     <= packet_len_in;
      end
   end

   // Next state and the label of the current dword.
   always_comb begin
      phase_in          = phase_ff;
      header_left_in    = header_left_ff;
      payload_left_in   = payload_left_ff;
      digest_pending_in = digest_pending_ff;
      packet_len_in     = packet_len_ff;
      item.kind         = ptd_pkg::KIND_HEADER;
      item.dword        = raw_dword;
      item.eop          = 1'b0;

      case (phase_ff)
         ptd_pkg::PHASE_LEAD: begin
            if (fmt == ptd_pkg::FMT_PREFIX) begin
               item.kind     = ptd_pkg::KIND_PREFIX;
               packet_len_in = '0;
            end else if (bad_leader) begin
               item.kind         = ptd_pkg::KIND_MALFORMED;
               packet_len_in     = '0;
               header_left_in    = '0;
               payload_left_in   = '0;
               digest_pending_in = 1'b0;
               item.eop          = 1'b1;
            end else begin
               item.kind         = ptd_pkg::KIND_HEADER;
               header_left_in    = fmt[0] ? 2'd3 : 2'd2;
               payload_left_in   = (fmt >= ptd_pkg::FMT_FIRST_DATA) ? len_decoded : '0;
               packet_len_in     = (fmt >= ptd_pkg::FMT_FIRST_DATA) ? len_decoded : '0;
               digest_pending_in = td;
               phase_in          = ptd_pkg::PHASE_HEADER;
            end
         end
         ptd_pkg::PHASE_HEADER: begin
            item.kind = ptd_pkg::KIND_HEADER;
            if (header_left_ff > 2'd1) begin
               header_left_in = header_left_ff - 2'd1;
            end else begin
               header_left_in = '0;
               if (payload_left_ff != '0) begin
                  phase_in = ptd_pkg::PHASE_PAYLOAD;
               end else if (digest_pending_ff) begin
                  phase_in = ptd_pkg::PHASE_DIGEST;
               end else begin
                  phase_in = ptd_pkg::PHASE_LEAD;
                  item.eop = 1'b1;
               end
            end
         end
         ptd_pkg::PHASE_PAYLOAD: begin
            item.kind = ptd_pkg::KIND_PAYLOAD;
            if (payload_left_ff > 11'd1) begin
               payload_left_in = payload_left_ff - 11'd1;
            end else begin
               payload_left_in = '0;
               if (digest_pending_ff) begin
                  phase_in = ptd_pkg::PHASE_DIGEST;
               end else begin
                  phase_in = ptd_pkg::PHASE_LEAD;
                  item.eop = 1'b1;
               end
            end
         end
         default: begin
            item.kind         = ptd_pkg::KIND_DIGEST;
            digest_pending_in = 1'b0;
            phase_in          = ptd_pkg::PHASE_LEAD;
            item.eop          = 1'b1;
         end
      endcase

      // The reported length is the one left by this dword.
      item.len = packet_len_in;
   end

endmodule

@@ hdl/ptd_queue.sv @@
// ----------------------------------------------------------------------------
// ptd_queue: short item queue between front and back
// A small circular buffer of classified items, so that each side can stall
// without holding up the other.
// ----------------------------------------------------------------------------
module ptd_queue #(
   parameter int DEPTH = ptd_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ptd_pkg::item_type       push_item,
   input  logic                    pop,
   output ptd_pkg::item_type       head_item,
   output ptd_pkg::q_status_type   status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ptd_pkg::item_type   entries_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; the count guards it.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);

endmodule

@@ hdl/ptd_back.sv @@
// ----------------------------------------------------------------------------
// ptd_back: result stage
// Takes items from the queue, puts header dwords into host byte order and
// holds the oldest result in an output register until it is popped.
// ----------------------------------------------------------------------------
module ptd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  ptd_pkg::item_type             head_item,
   input  ptd_pkg::q_status_type         q_status,
   output logic                          q_pop,
   input  logic                          out_pop,
   output logic                          out_empty,
   output ptd_pkg::item_type             out_item
);

   logic                 out_valid_ff, out_valid_in;
   ptd_pkg::item_type    out_item_ff, out_item_in;
   logic                 load;

   // Refill the output register when it is free or being emptied.
   assign load = !q_status.empty && (!out_valid_ff || out_pop);

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_item_in  = head_item;
         if (head_item.kind == ptd_pkg::KIND_HEADER) begin
            out_item_in.dword = ptd_pkg::swap32(head_item.dword);
         end
      end else if (out_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff <= out_item_in;
   end

   assign q_pop     = load;
   assign out_empty = !out_valid_ff;
   assign out_item  = out_item_ff;

endmodule
